>>> hw/rtl/complex_ratio_divider_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the complex ratio divider
// Concurrent assertion wrappers that can be compiled out.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_RATIO_DIVIDER_CORE_MACROS_SVH
`define COMPLEX_RATIO_DIVIDER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CRD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/crd_pkg.sv
// ----------------------------------------------------------------------------
// Complex ratio divider package
// Shared constants, status codes and the flag bundle between pipeline parts.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int CRD_SAMPLE_BITS = 24;
  localparam int CRD_FRAC_BITS   = 16;
  localparam int CRD_RATIO_W     = 32;

  localparam logic [2:0] CRD_ADDR_RESP_PORT  = 3'd0;
  localparam logic [2:0] CRD_ADDR_PORT_COUNT = 3'd4;

  localparam logic [1:0] CRD_RESP_PORT_RST  = 2'd1;
  localparam logic [2:0] CRD_PORT_COUNT_RST = 3'd2;
  localparam logic [1:0] CRD_MAX_SAMPLED_PORT = 2'd2;

  typedef enum logic [1:0] {
    CRD_ST_OK       = 2'd0,
    CRD_ST_ZERO_REF = 2'd1,
    CRD_ST_SAT      = 2'd2,
    CRD_ST_BAD_PORT = 2'd3
  } crd_status_e;

  typedef struct packed {
    logic bad_port;
    logic zero_ref;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } crd_flags_t;

endpackage

>>> hw/rtl/complex_ratio_divider_core.sv
// ----------------------------------------------------------------------------
// Complex ratio divider core
// Divides the selected response sample by the reference as complex numbers.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         one receiver sample: reference and both response IQ pairs
// m_axis    out        ratio real and imaginary in tdata, status in tuser
// apb       in/out     response_port at 0x0, port_count at 0x4
//
// One sample is taken per cycle unless s_axis_tready is low; each result passes through
// five front-end stages, 32 quotient-bit stages and the output register.
// The quotient pipeline is what sets the latency.
// Reset clears all valid bits and loads response_port 1 and port_count 2.
// A stall on m_axis holds each part only while its last stage is occupied, and
// s_axis_tready falls once the last front-end stage has to hold.
// ----------------------------------------------------------------------------
`include "complex_ratio_divider_core_macros.svh"

module complex_ratio_divider_core import crd_pkg::*; #(
  parameter int SAMPLE_BITS     = CRD_SAMPLE_BITS,
  parameter int RATIO_FRAC_BITS = CRD_FRAC_BITS,
  localparam int IN_W  = ((6 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int PW    = 2 * SAMPLE_BITS,
  localparam int RW    = PW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // ref_re, ref_im, port1_re, port1_im, port2_re, port2_im
  input  logic [IN_W-1:0] s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // ratio_re, ratio_im
  output logic [2*CRD_RATIO_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]      m_axis_tuser,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  localparam int SB = SAMPLE_BITS;
  localparam logic [CRD_RATIO_W-1:0] RATIO_MIN = {1'b1, {(CRD_RATIO_W-1){1'b0}}};
  localparam logic [CRD_RATIO_W-1:0] RATIO_MAX = {1'b0, {(CRD_RATIO_W-1){1'b1}}};

  logic [1:0] resp_port_q;
  logic [2:0] port_count_q;

  logic                   fr_valid, fr_ready;
  crd_flags_t             fr_flags;
  logic [PW-1:0]          fr_den;
  logic [RW-1:0]          fr_rre, fr_rim;
  logic [CRD_RATIO_W-1:0] fr_bre, fr_bim;

  logic                   dv_valid, dv_ready;
  crd_flags_t             dv_flags;
  logic [CRD_RATIO_W-1:0] dv_qre, dv_qim;

  logic                   out_en;
  logic                   out_v_q;
  logic [CRD_RATIO_W-1:0] ratio_re_d, ratio_re_q, ratio_im_d, ratio_im_q;
  crd_status_e            status_d, status_q;
  logic                   sat_re, sat_im;

  // Configuration port; registers are word addressed.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resp_port_q  <= CRD_RESP_PORT_RST;
      port_count_q <= CRD_PORT_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == CRD_ADDR_PORT_COUNT[2]) begin
        port_count_q <= pwdata[2:0];
      end else begin
        resp_port_q <= pwdata[1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CRD_ADDR_PORT_COUNT[2]) begin
      prdata = {29'd0, port_count_q};
    end else begin
      prdata = {30'd0, resp_port_q};
    end
  end

  crd_front #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .ref_re_i    (s_axis_tdata[0*SB +: SB]),
    .ref_im_i    (s_axis_tdata[1*SB +: SB]),
    .port1_re_i  (s_axis_tdata[2*SB +: SB]),
    .port1_im_i  (s_axis_tdata[3*SB +: SB]),
    .port2_re_i  (s_axis_tdata[4*SB +: SB]),
    .port2_im_i  (s_axis_tdata[5*SB +: SB]),
    .resp_port_i (resp_port_q),
    .port_count_i(port_count_q),
    .valid_o     (fr_valid),
    .ready_i     (fr_ready),
    .flags_o     (fr_flags),
    .den_o       (fr_den),
    .rem_re_o    (fr_rre),
    .rem_im_o    (fr_rim),
    .bits_re_o   (fr_bre),
    .bits_im_o   (fr_bim)
  );

  crd_divider #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_divider (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (fr_valid),
    .ready_o  (fr_ready),
    .flags_i  (fr_flags),
    .den_i    (fr_den),
    .rem_re_i (fr_rre),
    .rem_im_i (fr_rim),
    .bits_re_i(fr_bre),
    .bits_im_i(fr_bim),
    .valid_o  (dv_valid),
    .ready_i  (dv_ready),
    .flags_o  (dv_flags),
    .quo_re_o (dv_qre),
    .quo_im_o (dv_qim)
  );

  // Sign, saturation and status; a bad port setting takes precedence.
  always_comb begin
    if (dv_flags.neg_re) begin
      sat_re     = dv_flags.ovf_re || (dv_qre > {1'b1, {(CRD_RATIO_W-1){1'b0}}});
      ratio_re_d = sat_re ? {1'b1, {(CRD_RATIO_W-1){1'b0}}} : -dv_qre;
    end else begin
      sat_re     = dv_flags.ovf_re || dv_qre[CRD_RATIO_W-1];
      ratio_re_d = sat_re ? {1'b0, {(CRD_RATIO_W-1){1'b1}}} : dv_qre;
    end
    if (dv_flags.neg_im) begin
      sat_im     = dv_flags.ovf_im || (dv_qim > {1'b1, {(CRD_RATIO_W-1){1'b0}}});
      ratio_im_d = sat_im ? {1'b1, {(CRD_RATIO_W-1){1'b0}}} : -dv_qim;
    end else begin
      sat_im     = dv_flags.ovf_im || dv_qim[CRD_RATIO_W-1];
      ratio_im_d = sat_im ? {1'b0, {(CRD_RATIO_W-1){1'b1}}} : dv_qim;
    end
    status_d = (sat_re || sat_im) ? CRD_ST_SAT : CRD_ST_OK;
    if (dv_flags.bad_port) begin
      status_d   = CRD_ST_BAD_PORT;
      ratio_re_d = '0;
      ratio_im_d = '0;
    end else if (dv_flags.zero_ref) begin
      status_d   = CRD_ST_ZERO_REF;
      ratio_re_d = '0;
      ratio_im_d = '0;
    end
  end

  assign out_en   = m_axis_tready | ~out_v_q;
  assign dv_ready = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      ratio_re_q <= ratio_re_d;
      ratio_im_q <= ratio_im_d;
      status_q   <= status_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {ratio_im_q, ratio_re_q};
  assign m_axis_tuser  = status_q;

  `CRD_ASSERT_IMPLY(a_full_when_blocked, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid)
  `CRD_ASSERT_IMPLY(a_bad_port_zero, clk_i, rst_ni,
                    m_axis_tvalid && (status_q == CRD_ST_BAD_PORT), m_axis_tdata == '0)
  `CRD_ASSERT_IMPLY(a_zero_ref_zero, clk_i, rst_ni,
                    m_axis_tvalid && (status_q == CRD_ST_ZERO_REF), m_axis_tdata == '0)
  `CRD_ASSERT_IMPLY(a_sat_limit, clk_i, rst_ni,
                    m_axis_tvalid && (status_q == CRD_ST_SAT),
                    (ratio_re_q == RATIO_MIN) || (ratio_re_q == RATIO_MAX) ||
                    (ratio_im_q == RATIO_MIN) || (ratio_im_q == RATIO_MAX))

endmodule

>>> hw/rtl/crd_front.sv
// ----------------------------------------------------------------------------
// Complex ratio divider front end
// Port select, cross products, sums, magnitudes and the overflow pre-check.
// ----------------------------------------------------------------------------
module crd_front import crd_pkg::*; #(
  parameter int SAMPLE_BITS     = CRD_SAMPLE_BITS,
  parameter int RATIO_FRAC_BITS = CRD_FRAC_BITS,
  localparam int PW = 2 * SAMPLE_BITS,
  localparam int RW = PW + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SAMPLE_BITS-1:0] ref_re_i,
  input  logic [SAMPLE_BITS-1:0] ref_im_i,
  input  logic [SAMPLE_BITS-1:0] port1_re_i,
  input  logic [SAMPLE_BITS-1:0] port1_im_i,
  input  logic [SAMPLE_BITS-1:0] port2_re_i,
  input  logic [SAMPLE_BITS-1:0] port2_im_i,
  input  logic [1:0]             resp_port_i,
  input  logic [2:0]             port_count_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output crd_flags_t             flags_o,
  output logic [PW-1:0]          den_o,
  output logic [RW-1:0]          rem_re_o,
  output logic [RW-1:0]          rem_im_o,
  output logic [CRD_RATIO_W-1:0] bits_re_o,
  output logic [CRD_RATIO_W-1:0] bits_im_o
);

  localparam int SH = CRD_RATIO_W - RATIO_FRAC_BITS;
  localparam int CW = PW + SH;
  localparam int XW = CRD_RATIO_W + PW + RATIO_FRAC_BITS;

  logic [5:1] v_q;
  logic       en;

  logic signed [SAMPLE_BITS-1:0] a1_q, b1_q, c1_q, d1_q;
  logic signed [PW-1:0]          ac2_q, bd2_q, bc2_q, ad2_q, cc2_q, dd2_q;
  logic signed [PW:0]            re3_q, im3_q;
  logic [PW-1:0]                 den3_q, den4_q, den5_q;
  logic [PW-1:0]                 mre4_q, mim4_q;
  logic [RW-1:0]                 rre5_q, rim5_q;
  logic [CRD_RATIO_W-1:0]        bre5_q, bim5_q;
  crd_flags_t                    f1_d, f1_q, f2_q, f3_q, f4_d, f4_q, f5_d, f5_q;

  logic [CW-1:0] lim;
  logic [XW-1:0] xre, xim;

  assign en      = ready_i | ~v_q[5];
  assign ready_o = en;

  always_comb begin
    f1_d          = '0;
    f1_d.bad_port = (resp_port_i == 2'd0) || ({1'b0, resp_port_i} > port_count_i) ||
                    (resp_port_i > CRD_MAX_SAMPLED_PORT);
    f1_d.zero_ref = (ref_re_i == '0) && (ref_im_i == '0);
  end

  always_comb begin
    f4_d        = f3_q;
    f4_d.neg_re = re3_q[PW];
    f4_d.neg_im = im3_q[PW];
  end

  // The quotient fits in 32 bits only if num * 2^F < den * 2^32.
  always_comb begin
    lim         = CW'(den4_q) << SH;
    f5_d        = f4_q;
    f5_d.ovf_re = CW'(mre4_q) >= lim;
    f5_d.ovf_im = CW'(mim4_q) >= lim;
    xre         = XW'({mre4_q, {RATIO_FRAC_BITS{1'b0}}});
    xim         = XW'({mim4_q, {RATIO_FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q   <= (resp_port_i == 2'd1) ? port1_re_i : port2_re_i;
      b1_q   <= (resp_port_i == 2'd1) ? port1_im_i : port2_im_i;
      c1_q   <= ref_re_i;
      d1_q   <= ref_im_i;
      f1_q   <= f1_d;
      ac2_q  <= a1_q * c1_q;
      bd2_q  <= b1_q * d1_q;
      bc2_q  <= b1_q * c1_q;
      ad2_q  <= a1_q * d1_q;
      cc2_q  <= c1_q * c1_q;
      dd2_q  <= d1_q * d1_q;
      f2_q   <= f1_q;
      re3_q  <= (PW + 1)'(ac2_q) + (PW + 1)'(bd2_q);
      im3_q  <= (PW + 1)'(bc2_q) - (PW + 1)'(ad2_q);
      den3_q <= PW'($unsigned(cc2_q) + $unsigned(dd2_q));
      f3_q   <= f2_q;
      mre4_q <= PW'(re3_q[PW] ? -re3_q : re3_q);
      mim4_q <= PW'(im3_q[PW] ? -im3_q : im3_q);
      den4_q <= den3_q;
      f4_q   <= f4_d;
      rre5_q <= xre[CRD_RATIO_W +: RW];
      rim5_q <= xim[CRD_RATIO_W +: RW];
      bre5_q <= xre[CRD_RATIO_W-1:0];
      bim5_q <= xim[CRD_RATIO_W-1:0];
      den5_q <= den4_q;
      f5_q   <= f5_d;
    end
  end

  assign valid_o   = v_q[5];
  assign flags_o   = f5_q;
  assign den_o     = den5_q;
  assign rem_re_o  = rre5_q;
  assign rem_im_o  = rim5_q;
  assign bits_re_o = bre5_q;
  assign bits_im_o = bim5_q;

endmodule

>>> hw/rtl/crd_divider.sv
// ----------------------------------------------------------------------------
// Complex ratio divider quotient pipeline
// Restoring division, one quotient bit per stage, both parts side by side.
// ----------------------------------------------------------------------------
module crd_divider import crd_pkg::*; #(
  parameter int SAMPLE_BITS = CRD_SAMPLE_BITS,
  localparam int PW = 2 * SAMPLE_BITS,
  localparam int RW = PW + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  crd_flags_t             flags_i,
  input  logic [PW-1:0]          den_i,
  input  logic [RW-1:0]          rem_re_i,
  input  logic [RW-1:0]          rem_im_i,
  input  logic [CRD_RATIO_W-1:0] bits_re_i,
  input  logic [CRD_RATIO_W-1:0] bits_im_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output crd_flags_t             flags_o,
  output logic [CRD_RATIO_W-1:0] quo_re_o,
  output logic [CRD_RATIO_W-1:0] quo_im_o
);

  localparam int STEPS = CRD_RATIO_W;
  localparam int QW    = CRD_RATIO_W;

  logic [STEPS-1:0] v_q;
  logic             en;

  logic [PW-1:0]  den_q  [STEPS];
  logic [RW-1:0]  rre_q  [STEPS];
  logic [RW-1:0]  rim_q  [STEPS];
  logic [QW-1:0]  bre_q  [STEPS];
  logic [QW-1:0]  bim_q  [STEPS];
  logic [QW-1:0]  qre_q  [STEPS];
  logic [QW-1:0]  qim_q  [STEPS];
  crd_flags_t     f_q    [STEPS];

  assign en      = ready_i | ~v_q[STEPS-1];
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[STEPS-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [PW-1:0] den_in;
    logic [RW-1:0] rre_in, rim_in, rre_sh, rim_sh;
    logic [QW-1:0] bre_in, bim_in, qre_in, qim_in;
    crd_flags_t    f_in;
    logic          ge_re, ge_im;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign rre_in = rem_re_i;
      assign rim_in = rem_im_i;
      assign bre_in = bits_re_i;
      assign bim_in = bits_im_i;
      assign qre_in = '0;
      assign qim_in = '0;
      assign f_in   = flags_i;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign rre_in = rre_q[k-1];
      assign rim_in = rim_q[k-1];
      assign bre_in = bre_q[k-1];
      assign bim_in = bim_q[k-1];
      assign qre_in = qre_q[k-1];
      assign qim_in = qim_q[k-1];
      assign f_in   = f_q[k-1];
    end

    // The partial remainder stays below the divisor, so one shift fits in RW bits.
    assign rre_sh = {rre_in[RW-2:0], bre_in[QW-1]};
    assign rim_sh = {rim_in[RW-2:0], bim_in[QW-1]};
    assign ge_re  = rre_sh >= {1'b0, den_in};
    assign ge_im  = rim_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en) begin
        den_q[k] <= den_in;
        rre_q[k] <= ge_re ? rre_sh - {1'b0, den_in} : rre_sh;
        rim_q[k] <= ge_im ? rim_sh - {1'b0, den_in} : rim_sh;
        bre_q[k] <= bre_in << 1;
        bim_q[k] <= bim_in << 1;
        qre_q[k] <= {qre_in[QW-2:0], ge_re};
        qim_q[k] <= {qim_in[QW-2:0], ge_im};
        f_q[k]   <= f_in;
      end
    end
  end

  assign valid_o  = v_q[STEPS-1];
  assign flags_o  = f_q[STEPS-1];
  assign quo_re_o = qre_q[STEPS-1];
  assign quo_im_o = qim_q[STEPS-1];

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Complex ratio divider testbench
// Streams receiver samples through the divider under random source gaps and
// sink stalls, predicts each complex ratio and status in the bench, and
// compares every output transfer in order. Register settings are changed only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import crd_pkg::*;

  localparam int SB   = CRD_SAMPLE_BITS;
  localparam int IN_W = ((6 * SB + 7) / 8) * 8;
  localparam int LAT  = 38;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    crd_status_e st;
  } ratio_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  complex_ratio_divider_core dut (.*);

  always #5 clk_i = ~clk_i;

  ratio_t ratio_q[$];
  logic [1:0] resp_port = CRD_RESP_PORT_RST;
  logic [2:0] num_ports = CRD_PORT_COUNT_RST;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int burst_left = 0;
  bit stall_mode = 1'b0;

  // Truncated (num * 2^16) / den with saturation to a signed 32-bit word.
  function automatic logic [31:0] scaled_quot(input logic signed [49:0] num,
                                              input logic [48:0] den,
                                              inout bit sat);
    logic [49:0] mag;
    logic [79:0] q;
    mag = num[49] ? -num : num;
    q = ({30'd0, mag} << CRD_FRAC_BITS) / den;
    if (!num[49]) begin
      if (q > 80'h7FFFFFFF) begin
        sat = 1'b1;
        return 32'h7FFFFFFF;
      end
      return q[31:0];
    end
    if (q > 80'h80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return -q[31:0];
  endfunction

  function automatic ratio_t divide_sample(input logic [IN_W-1:0] d);
    ratio_t r;
    logic signed [SB-1:0] c, dd, a, b;
    logic signed [49:0] cw, dw, aw, bw;
    logic signed [49:0] nre, nim;
    logic [48:0] den;
    bit sat;
    r = '{re: '0, im: '0, st: CRD_ST_OK};
    sat = 1'b0;
    c = d[0 +: SB];
    dd = d[SB +: SB];
    if (resp_port < 1 || resp_port > num_ports || resp_port > CRD_MAX_SAMPLED_PORT) begin
      r.st = CRD_ST_BAD_PORT;
      return r;
    end
    if (c == 0 && dd == 0) begin
      r.st = CRD_ST_ZERO_REF;
      return r;
    end
    a = (resp_port == 1) ? d[2*SB +: SB] : d[4*SB +: SB];
    b = (resp_port == 1) ? d[3*SB +: SB] : d[5*SB +: SB];
    cw = 50'(c);
    dw = 50'(dd);
    aw = 50'(a);
    bw = 50'(b);
    den = 49'(cw * cw + dw * dw);
    nre = aw * cw + bw * dw;
    nim = bw * cw - aw * dw;
    r.re = scaled_quot(nre, den, sat);
    r.im = scaled_quot(nim, den, sat);
    r.st = sat ? CRD_ST_SAT : CRD_ST_OK;
    return r;
  endfunction

  // Sink stall pattern: alternates between always ready and random stalls.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  always @(posedge clk_i) begin
    ratio_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ratio_q.size() == 0) begin
        $display("%0t: unexpected result %h status %0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        exp_r = ratio_q.pop_front();
        n_checked++;
        if (m_axis_tdata[31:0] !== exp_r.re)
          $display("%0t: ratio_re expected %h actual %h", $time, exp_r.re,
                   m_axis_tdata[31:0]);
        if (m_axis_tdata[63:32] !== exp_r.im)
          $display("%0t: ratio_im expected %h actual %h", $time, exp_r.im,
                   m_axis_tdata[63:32]);
        if (m_axis_tuser !== exp_r.st)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st,
                   m_axis_tuser);
        if (m_axis_tdata !== {exp_r.im, exp_r.re} || m_axis_tuser !== exp_r.st)
          errors++;
      end
    end
  end

  // Valid stays high across back-to-back transfers within a burst.
  task automatic send_sample(input logic [IN_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ratio_q = {ratio_q, divide_sample(d)};
    n_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (ratio_q.size() != 0) @(negedge clk_i);
    repeat (LAT + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (addr == CRD_ADDR_RESP_PORT) resp_port = val[1:0];
    else num_ports = val[2:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [SB-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SB-1){1'b1}}};
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return '0;
      3: return SB'($signed($urandom_range(0, 8)) - 4);
      4: return SB'($urandom_range(0, 255));
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [IN_W-1:0] rand_sample();
    logic [IN_W-1:0] d;
    d = '0;
    for (int i = 0; i < 6; i++) d[i*SB +: SB] = rand_field();
    // Small references make saturation likely.
    if ($urandom_range(0, 3) == 0) begin
      d[0 +: SB] = SB'($signed($urandom_range(0, 6)) - 3);
      d[SB +: SB] = SB'($signed($urandom_range(0, 6)) - 3);
    end
    return d;
  endfunction

  function automatic logic [IN_W-1:0] pack6(input int c, input int dd,
                                            input int a1, input int b1,
                                            input int a2, input int b2);
    return {SB'(b2), SB'(a2), SB'(b1), SB'(a1), SB'(dd), SB'(c)};
  endfunction

  task automatic test_directed();
    localparam int MX = 8388607;
    localparam int MN = -8388608;
    send_sample(pack6(1, 0, 3, -2, 5, 7));
    send_sample(pack6(0, 0, 9, 9, 9, 9));
    send_sample(pack6(MX, MX, MX, MN, MN, MX));
    send_sample(pack6(MN, MN, MN, MN, MX, MX));
    send_sample(pack6(1, 1, MX, MX, MN, MN));
    send_sample(pack6(1, 0, MN, MN, MX, MX));
    send_sample(pack6(MX, 0, 1, 0, 0, 1));
    send_sample(pack6(0, MN, 0, 0, 0, 0));
    send_sample(pack6(3, -4, 7, 11, -13, 2));
    send_sample(pack6(-1, 0, 32768, -32768, 0, 0));
    drain_pipeline();
    write_reg(CRD_ADDR_RESP_PORT, 32'd2);
    send_sample(pack6(1, 0, 3, -2, 5, 7));
    send_sample(pack6(-1, 0, MN, MN, MN, MN));
    send_sample(pack6(0, 0, 1, 1, 1, 1));
    drain_pipeline();
    write_reg(CRD_ADDR_PORT_COUNT, 32'd1);
    send_sample(pack6(1, 0, 3, -2, 5, 7));
    drain_pipeline();
    write_reg(CRD_ADDR_RESP_PORT, 32'd0);
    write_reg(CRD_ADDR_PORT_COUNT, 32'd4);
    send_sample(pack6(1, 0, 3, -2, 5, 7));
    drain_pipeline();
    write_reg(CRD_ADDR_RESP_PORT, 32'hFFFF_FFFF);
    send_sample(pack6(1, 0, 3, -2, 5, 7));
    drain_pipeline();
  endtask

  task automatic test_random_settings();
    logic [31:0] rp, pc;
    for (int ph = 0; ph < 9; ph++) begin
      rp = (ph < 6) ? 32'(1 + ph % 2) : $urandom;
      pc = (ph < 6) ? 32'(2 + ph % 3) : $urandom;
      if (ph == 8) pc = 32'h0000_0007;
      write_reg(CRD_ADDR_RESP_PORT, rp);
      write_reg(CRD_ADDR_PORT_COUNT, pc);
      for (int i = 0; i < 150; i++) begin
        send_sample(rand_sample());
        if (i == 75) drain_pipeline();
      end
      drain_pipeline();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_settings();
    drain_pipeline();
    $display("Sent %0d samples, checked %0d ratios across directed and random",
             n_sent, n_checked);
    $display("register settings, with source gaps and sink stalls.");
    if (errors == 0 && ratio_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
